/* src/wireworld_generation_engine_defines.svh */
// Assertion macros shared by the Wireworld generation engine RTL.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef WIREWORLD_GENERATION_ENGINE_DEFINES_SVH
`define WIREWORLD_GENERATION_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WGE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WGE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wge_pkg.sv */
// Shared types, codes and the cell rule of the Wireworld generation engine.
// No dependencies.
`default_nettype none

package wge_pkg;

    localparam int CMD_W      = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int CELL_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] OP_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] OP_READ  = 2'd1;
    localparam logic [CMD_W-1:0] OP_STEP  = 2'd2;

    // cell codes
    localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
    localparam logic [CELL_W-1:0] CELL_HEAD  = 2'd1;
    localparam logic [CELL_W-1:0] CELL_TAIL  = 2'd2;
    localparam logic [CELL_W-1:0] CELL_COND  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_EDGES  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 7'd64;
    localparam logic                  WRAP_RESET     = 1'b0;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] cell_value;
    } wge_cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] read_value;
        logic              status;
    } wge_rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } wge_cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_ACC_WB,
        ST_STEP_ROW,
        ST_RD_MID,
        ST_RD_DN,
        ST_ROW_WR,
        ST_SWAP,
        ST_RESP
    } wge_state_t;

    typedef enum logic [1:0] {
        RD_ACCESS,
        RD_UP,
        RD_MID,
        RD_DN
    } wge_rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_CELL,
        WR_ZERO_ROW,
        WR_NEXT_ROW
    } wge_wr_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic         cmd_load;
        logic         rd_en;
        wge_rd_sel_t  rd_sel;
        wge_wr_kind_t wr_kind;
        logic         row_clr;
        logic         row_inc;
        logic         cap_up;
        logic         cap_mid;
        logic         cap_val;
        logic         bank_swap;
        logic         rsp_load;
    } wge_dp_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             bad;
        logic             row_in_grid;
        logic             row_last;
    } wge_dp_stat_t;

    // Wireworld rule for one cell given its head-neighbour count
    function automatic logic [CELL_W-1:0] wge_next_cell(
        input logic [CELL_W-1:0] cur_cell,
        input logic [3:0]        heads
    );
        logic [CELL_W-1:0] nxt;
        case (cur_cell)
            CELL_EMPTY: nxt = CELL_EMPTY;
            CELL_HEAD:  nxt = CELL_TAIL;
            CELL_TAIL:  nxt = CELL_COND;
            default:    nxt = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_COND;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

/* src/wge_stream_if.sv */
// Valid/ready channel carrying one payload struct per transaction.
// Payload types come from wge_pkg.
`default_nettype none

interface wge_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/wireworld_generation_engine.sv */
// A write or read goes from accept through DISPATCH, ACC_WB and RESP to response
// valid; a bad access skips ACC_WB. A new command is taken only once the last one
// has loaded its response. A step walks the banks one row at a time: a row in use
// is read above, at and below and written; an unused row is zeroed; then SWAP.
// Reset: async, active low; a clearing pass then zeroes both banks, one row a
// cycle over all MAX_HEIGHT rows, before the first command transaction is taken.
`default_nettype none

// Wireworld generation engine, top level.
//
// The grid lives in two banks, each MAX_HEIGHT words of one row
// (MAX_WIDTH cells of 2 bits). One bank is current and serves read and write
// transactions; the other is scratch for the next generation.
//
// Cell write: read-modify-write of the row holding the cell.
// Cell read:  one row read, cell picked from the registered read data.
// Step:       for every row in use, the rows above, at and below are read
//             (wrapped or masked to empty at the edges) and a bank of per-column
//             lanes produces the whole next row, written to scratch. Rows past
//             the grid height are written empty. Then the banks swap.
//
// The response register decouples the result side: a new command transaction
// is taken while the previous response still waits to be taken.
// Configuration writes are taken on every cycle and land immediately.
module wireworld_generation_engine #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wge_stream_if.sink    cmd,
    wge_stream_if.source  rsp,
    wge_stream_if.sink    cfg
);

    wge_pkg::wge_dp_ctl_t  dp_ctl;
    wge_pkg::wge_dp_stat_t dp_stat;

    // sequencing only; no payload passes through here
    wge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (dp_stat),
        .ctl       (dp_ctl)
    );

    // banks, configuration and the row lanes
    wge_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd.data),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_data  (cfg.data),
        .rsp_data  (rsp.data),
        .ctl       (dp_ctl),
        .stat      (dp_stat)
    );

endmodule

`default_nettype wire

/* src/wge_row_lanes.sv */
// One lane per column: counts head neighbours and applies the cell rule
// to a whole row at once. Depends on wge_pkg.
`default_nettype none

module wge_row_lanes #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic [2*MAX_WIDTH-1:0]          up_row,
    input  wire logic [2*MAX_WIDTH-1:0]          mid_row,
    input  wire logic [2*MAX_WIDTH-1:0]          dn_row,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  eff_w,
    input  wire logic                            wrap,
    output logic      [2*MAX_WIDTH-1:0]          next_row
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int CI_W = $clog2(MAX_WIDTH);

    logic [MAX_WIDTH-1:0] hd_up;
    logic [MAX_WIDTH-1:0] hd_mid;
    logic [MAX_WIDTH-1:0] hd_dn;
    logic [CW-1:0]        last_col;
    logic [CI_W-1:0]      last_idx;
    logic                 wl_up, wl_mid, wl_dn;
    logic                 wr_up, wr_mid, wr_dn;

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            hd_up[c]  = (up_row[2*c +: 2]  == wge_pkg::CELL_HEAD);
            hd_mid[c] = (mid_row[2*c +: 2] == wge_pkg::CELL_HEAD);
            hd_dn[c]  = (dn_row[2*c +: 2]  == wge_pkg::CELL_HEAD);
        end
    end

    assign last_col = eff_w - CW'(1);
    assign last_idx = CI_W'(last_col);

    // wrapped neighbours across the left and right edge
    assign wl_up  = wrap & hd_up[last_idx];
    assign wl_mid = wrap & hd_mid[last_idx];
    assign wl_dn  = wrap & hd_dn[last_idx];
    assign wr_up  = wrap & hd_up[0];
    assign wr_mid = wrap & hd_mid[0];
    assign wr_dn  = wrap & hd_dn[0];

    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_lane
        logic       l_up, l_mid, l_dn;
        logic       r_up, r_mid, r_dn;
        logic       at_right;
        logic [3:0] heads;

        assign at_right = (CW'(c) == last_col);

        if (c == 0)
        begin : g_left_edge
            assign l_up  = wl_up;
            assign l_mid = wl_mid;
            assign l_dn  = wl_dn;
        end
        else
        begin : g_left
            assign l_up  = hd_up[c-1];
            assign l_mid = hd_mid[c-1];
            assign l_dn  = hd_dn[c-1];
        end

        // last lane: only meaningful when it is the right edge of the grid
        if (c == MAX_WIDTH - 1)
        begin : g_right_edge
            assign r_up  = at_right & wr_up;
            assign r_mid = at_right & wr_mid;
            assign r_dn  = at_right & wr_dn;
        end
        else
        begin : g_right
            assign r_up  = at_right ? wr_up  : hd_up[c+1];
            assign r_mid = at_right ? wr_mid : hd_mid[c+1];
            assign r_dn  = at_right ? wr_dn  : hd_dn[c+1];
        end

        assign heads = {3'b000, l_up}  + {3'b000, hd_up[c]} + {3'b000, r_up}
                     + {3'b000, l_mid} + {3'b000, r_mid}
                     + {3'b000, l_dn}  + {3'b000, hd_dn[c]} + {3'b000, r_dn};

        assign next_row[2*c +: 2] = (CW'(c) < eff_w)
                                  ? wge_pkg::wge_next_cell(mid_row[2*c +: 2], heads)
                                  : wge_pkg::CELL_EMPTY;
    end

endmodule

`default_nettype wire

/* src/wge_datapath.sv */
// Datapath: both cell banks (one row per word), configuration registers,
// row counter, row capture, next-row lanes and response register.
// Depends on wge_pkg, wge_row_lanes and the assertion macro header.
`default_nettype none
`include "wireworld_generation_engine_defines.svh"

module wge_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wge_pkg::wge_cmd_t     cmd_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire wge_pkg::wge_cfg_t     cfg_data,
    output wge_pkg::wge_rsp_t          rsp_data,
    input  wire wge_pkg::wge_dp_ctl_t  ctl,
    output wge_pkg::wge_dp_stat_t      stat
);

    localparam int ROW_BITS = 2 * MAX_WIDTH;
    localparam int RA_W     = $clog2(MAX_HEIGHT);
    localparam int CI_W     = $clog2(MAX_WIDTH);
    localparam int CW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);

    logic [ROW_BITS-1:0] bank_a_mem [MAX_HEIGHT];
    logic [ROW_BITS-1:0] bank_b_mem [MAX_HEIGHT];
    logic [ROW_BITS-1:0] rd_a_reg;
    logic [ROW_BITS-1:0] rd_b_reg;
    logic [ROW_BITS-1:0] rd_data;
    logic [ROW_BITS-1:0] up_row_reg;
    logic [ROW_BITS-1:0] mid_row_reg;
    logic [ROW_BITS-1:0] merged_row;
    logic [ROW_BITS-1:0] next_row;
    logic [ROW_BITS-1:0] lane_up;
    logic [ROW_BITS-1:0] lane_dn;
    logic [ROW_BITS-1:0] wr_data;

    wge_pkg::wge_cmd_t                    cmd_reg;
    wge_pkg::wge_rsp_t                    rsp_data_reg;
    logic [wge_pkg::CFG_DATA_W-1:0]       width_cfg_reg;
    logic [wge_pkg::CFG_DATA_W-1:0]       height_cfg_reg;
    logic                                 wrap_reg;
    logic                                 bank_sel_reg;
    logic [RA_W-1:0]                      row_cnt_reg;
    logic [wge_pkg::CELL_W-1:0]           val_reg;

    logic [CW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic [RA_W-1:0] last_grid_row;
    logic [RA_W-1:0] acc_row;
    logic [CI_W-1:0] acc_col;
    logic [RA_W-1:0] up_addr;
    logic [RA_W-1:0] dn_addr;
    logic [RA_W-1:0] rd_addr;
    logic [RA_W-1:0] wr_addr;
    logic            access_ok;
    logic            up_ok;
    logic            dn_ok;
    logic            wr_en_a;
    logic            wr_en_b;

    // effective grid size: zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (width_cfg_reg == '0)
            eff_w = CW'(1);
        else if (int'(width_cfg_reg) > MAX_WIDTH)
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            eff_h = HW'(1);
        else if (int'(height_cfg_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_cfg_reg);
    end

    assign last_grid_row = RA_W'(eff_h - HW'(1));
    assign acc_row       = RA_W'(cmd_reg.row);
    assign acc_col       = CI_W'(cmd_reg.col);
    assign access_ok     = (int'(cmd_reg.row) < int'(eff_h)) && (int'(cmd_reg.col) < int'(eff_w));

    assign up_addr = (row_cnt_reg == '0) ? last_grid_row : row_cnt_reg - RA_W'(1);
    assign dn_addr = (row_cnt_reg == last_grid_row) ? '0 : row_cnt_reg + RA_W'(1);
    assign up_ok   = wrap_reg || (row_cnt_reg != '0);
    assign dn_ok   = wrap_reg || (row_cnt_reg != last_grid_row);

    // status back to the controller
    always_comb
    begin
        stat.op          = cmd_reg.command;
        stat.row_in_grid = int'(row_cnt_reg) < int'(eff_h);
        stat.row_last    = (row_cnt_reg == RA_W'(MAX_HEIGHT - 1));
        case (cmd_reg.command) inside
            wge_pkg::OP_WRITE, wge_pkg::OP_READ: stat.bad = !access_ok;
            wge_pkg::OP_STEP:                    stat.bad = wge_pkg::STATUS_DONE;
            default:                             stat.bad = wge_pkg::STATUS_BAD;
        endcase
    end

    // configuration port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= wge_pkg::GRID_DIM_RESET;
            height_cfg_reg <= wge_pkg::GRID_DIM_RESET;
            wrap_reg       <= wge_pkg::WRAP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_data.index)
                wge_pkg::REG_GRID_WIDTH:  width_cfg_reg  <= cfg_data.value;
                wge_pkg::REG_GRID_HEIGHT: height_cfg_reg <= cfg_data.value;
                wge_pkg::REG_WRAP_EDGES:  wrap_reg       <= cfg_data.value[0];
                default: ;
            endcase
        end
    end

    // control state: bank select and row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_sel_reg <= 1'b0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            if (ctl.bank_swap)
                bank_sel_reg <= !bank_sel_reg;
            if (ctl.row_clr)
                row_cnt_reg <= '0;
            else if (ctl.row_inc)
                row_cnt_reg <= row_cnt_reg + RA_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.cmd_load)
            cmd_reg <= cmd_data;
        if (ctl.cap_up)
            up_row_reg <= rd_data;
        if (ctl.cap_mid)
            mid_row_reg <= rd_data;
        if (ctl.cap_val)
            val_reg <= rd_data[2*acc_col +: 2];
        if (ctl.rsp_load)
        begin
            rsp_data_reg.read_value <= (cmd_reg.command == wge_pkg::OP_READ && access_ok)
                                     ? val_reg : wge_pkg::CELL_EMPTY;
            rsp_data_reg.status     <= stat.bad;
        end
    end

    assign rsp_data = rsp_data_reg;

    // read address
    always_comb
    begin
        unique case (ctl.rd_sel)
            wge_pkg::RD_ACCESS: rd_addr = acc_row;
            wge_pkg::RD_UP:     rd_addr = up_addr;
            wge_pkg::RD_MID:    rd_addr = row_cnt_reg;
            wge_pkg::RD_DN:     rd_addr = dn_addr;
            default:            rd_addr = row_cnt_reg;
        endcase
    end

    assign rd_data = bank_sel_reg ? rd_b_reg : rd_a_reg;

    // single-cell write merges into the row just read
    always_comb
    begin
        merged_row                  = rd_data;
        merged_row[2*acc_col +: 2]  = cmd_reg.cell_value;
    end

    assign lane_up = up_ok ? up_row_reg : '0;
    assign lane_dn = dn_ok ? rd_data    : '0;

    wge_row_lanes #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lanes (
        .up_row   (lane_up),
        .mid_row  (mid_row_reg),
        .dn_row   (lane_dn),
        .eff_w    (eff_w),
        .wrap     (wrap_reg),
        .next_row (next_row)
    );

    // write port: clear hits both banks, cell write the current one,
    // generation rows the scratch one
    always_comb
    begin
        wr_addr = row_cnt_reg;
        wr_data = '0;
        wr_en_a = 1'b0;
        wr_en_b = 1'b0;
        unique case (ctl.wr_kind)
            wge_pkg::WR_NONE: ;
            wge_pkg::WR_CLEAR:
            begin
                wr_en_a = 1'b1;
                wr_en_b = 1'b1;
            end
            wge_pkg::WR_CELL:
            begin
                wr_addr = acc_row;
                wr_data = merged_row;
                wr_en_a = !bank_sel_reg;
                wr_en_b = bank_sel_reg;
            end
            wge_pkg::WR_ZERO_ROW:
            begin
                wr_en_a = bank_sel_reg;
                wr_en_b = !bank_sel_reg;
            end
            wge_pkg::WR_NEXT_ROW:
            begin
                wr_data = next_row;
                wr_en_a = bank_sel_reg;
                wr_en_b = !bank_sel_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_a)
            bank_a_mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_a_reg <= bank_a_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_b)
            bank_b_mem[wr_addr] <= wr_data;
        if (ctl.rd_en)
            rd_b_reg <= bank_b_mem[rd_addr];
    end

    `WGE_ASSERT_NOW(a_dual_write_only_clear, wr_en_a && wr_en_b, ctl.wr_kind == wge_pkg::WR_CLEAR, "both banks written outside clear")
    `WGE_ASSERT_NEXT(a_swap_toggles_bank, ctl.bank_swap, bank_sel_reg != $past(bank_sel_reg), "bank swap lost")
    `WGE_ASSERT_NOW(a_next_row_to_scratch, ctl.wr_kind == wge_pkg::WR_NEXT_ROW, wr_en_a == bank_sel_reg && wr_en_b == !bank_sel_reg, "generation row written to current bank")

endmodule

`default_nettype wire

/* src/wge_ctrl.sv */
// Controller state machine: clearing pass, command sequencing, row walk of
// a generation step and the response handshake. Depends on wge_pkg and the
// assertion macro header.
`default_nettype none
`include "wireworld_generation_engine_defines.svh"

module wge_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    input  wire wge_pkg::wge_dp_stat_t  stat,
    output wge_pkg::wge_dp_ctl_t        ctl
);

    wge_pkg::wge_state_t state_reg;
    wge_pkg::wge_state_t state_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wge_pkg::ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd_ready     = 1'b0;
        ctl.cmd_load  = 1'b0;
        ctl.rd_en     = 1'b0;
        ctl.rd_sel    = wge_pkg::RD_ACCESS;
        ctl.wr_kind   = wge_pkg::WR_NONE;
        ctl.row_clr   = 1'b0;
        ctl.row_inc   = 1'b0;
        ctl.cap_up    = 1'b0;
        ctl.cap_mid   = 1'b0;
        ctl.cap_val   = 1'b0;
        ctl.bank_swap = 1'b0;
        ctl.rsp_load  = 1'b0;

        unique case (state_reg)
            wge_pkg::ST_CLEAR:
            begin
                ctl.wr_kind = wge_pkg::WR_CLEAR;
                if (stat.row_last)
                    state_next = wge_pkg::ST_IDLE;
                else
                    ctl.row_inc = 1'b1;
            end
            wge_pkg::ST_IDLE:
            begin
                cmd_ready    = 1'b1;
                ctl.cmd_load = cmd_valid;
                if (cmd_valid)
                    state_next = wge_pkg::ST_DISPATCH;
            end
            wge_pkg::ST_DISPATCH:
            begin
                unique case (stat.op) inside
                    wge_pkg::OP_STEP:
                    begin
                        ctl.row_clr = 1'b1;
                        state_next  = wge_pkg::ST_STEP_ROW;
                    end
                    wge_pkg::OP_WRITE, wge_pkg::OP_READ:
                    begin
                        if (stat.bad)
                            state_next = wge_pkg::ST_RESP;
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = wge_pkg::RD_ACCESS;
                            state_next = wge_pkg::ST_ACC_WB;
                        end
                    end
                    default: state_next = wge_pkg::ST_RESP;
                endcase
            end
            wge_pkg::ST_ACC_WB:
            begin
                if (stat.op == wge_pkg::OP_WRITE)
                    ctl.wr_kind = wge_pkg::WR_CELL;
                else
                    ctl.cap_val = 1'b1;
                state_next = wge_pkg::ST_RESP;
            end
            wge_pkg::ST_STEP_ROW:
            begin
                if (stat.row_in_grid)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = wge_pkg::RD_UP;
                    state_next = wge_pkg::ST_RD_MID;
                end
                else
                begin
                    ctl.wr_kind = wge_pkg::WR_ZERO_ROW;
                    if (stat.row_last)
                        state_next = wge_pkg::ST_SWAP;
                    else
                        ctl.row_inc = 1'b1;
                end
            end
            wge_pkg::ST_RD_MID:
            begin
                ctl.cap_up = 1'b1;
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = wge_pkg::RD_MID;
                state_next = wge_pkg::ST_RD_DN;
            end
            wge_pkg::ST_RD_DN:
            begin
                ctl.cap_mid = 1'b1;
                ctl.rd_en   = 1'b1;
                ctl.rd_sel  = wge_pkg::RD_DN;
                state_next  = wge_pkg::ST_ROW_WR;
            end
            wge_pkg::ST_ROW_WR:
            begin
                ctl.wr_kind = wge_pkg::WR_NEXT_ROW;
                if (stat.row_last)
                    state_next = wge_pkg::ST_SWAP;
                else
                begin
                    ctl.row_inc = 1'b1;
                    state_next  = wge_pkg::ST_STEP_ROW;
                end
            end
            wge_pkg::ST_SWAP:
            begin
                ctl.bank_swap = 1'b1;
                state_next    = wge_pkg::ST_RESP;
            end
            wge_pkg::ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.rsp_load = 1'b1;
                    state_next   = wge_pkg::ST_IDLE;
                end
            end
            default: state_next = wge_pkg::ST_IDLE;
        endcase
    end

    assign rsp_valid_next = ctl.rsp_load || (rsp_valid_reg && !rsp_ready);

    `WGE_ASSERT_NEXT(a_accept_dispatches, cmd_valid && cmd_ready, state_reg == wge_pkg::ST_DISPATCH, "accepted transaction not dispatched")
    `WGE_ASSERT_NOW(a_rsp_no_overwrite, ctl.rsp_load, !rsp_valid_reg || rsp_ready, "pending response overwritten")
    `WGE_ASSERT_NOW(a_swap_after_last_row, state_reg == wge_pkg::ST_SWAP, $past(stat.row_last), "bank swap before last row")

endmodule

`default_nettype wire
